// ===== rtl/rtc3w_pkg.sv =====
// Shared types, codes and helper functions for the three-wire RTC link master.
// No dependencies; used by rtc3w_step and rtc_three_wire_master_core.
`timescale 1ns / 1ps

package rtc3w_pkg;

  // Command codes carried on the input tuser
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] ADDR_BASE  = 8'h80;
  localparam logic [2:0] WP_INDEX   = 3'd7;
  localparam logic [4:0] TOTAL_BITS = 5'd16;
  localparam logic [4:0] ADDR_BITS  = 5'd8;

  // Transfer mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_WRITE = 3'b010,
    MODE_READ  = 3'b100
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [4:0]  bit_count;
    logic        clock_phase;
    logic [15:0] shift_word;   // low byte address, high byte write data
    logic [7:0]  read_byte;
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] reg_index;
    logic [7:0] value;
    logic       io_in;
  } req_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       done_res;
    logic       busy_res;
    logic       data_drive;
    logic       data_out;
    logic       serial_clock;
    logic       chip_enable;
  } res_t;

  // Binary to BCD; tens digit by reciprocal multiply, exact for all 8-bit inputs
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  units;
    prod  = 16'(v) * 16'd205;
    tens  = prod[15:11];
    units = v - 8'(tens * 5'd10);
    return {tens[3:0], units[3:0]};
  endfunction

  // BCD to binary: high nibble times ten plus low nibble
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return 8'(b[7:4] * 8'd10) + {4'd0, b[3:0]};
  endfunction

endpackage

// ===== rtl/rtc_three_wire_master_core.sv =====
// Top level of the three-wire RTC link master: request/result stream stages and state.
// Depends on rtc3w_pkg and rtc3w_step.
`timescale 1ns / 1ps
//
// Usage:
//   Every request on the in_ channel is one half-bit tick of the serial clock.
//   in_tuser carries the command (tick, start write, start read); in_tdata
//   carries the register index, the write value and the sampled data pin.
//   Each request gives exactly one result on the out_ channel with the pin
//   levels for that tick (chip enable, serial clock, data out, data drive),
//   busy and done flags and the BCD-decoded read value.
//   A transfer takes 33 ticks: 16 bits of two ticks each plus the finishing
//   tick that pulses done. Starts while busy are ignored.
//   A request is registered in the input stage, runs through the combinational
//   tick logic between the two registers and lands in the output register.
//   One request per cycle is taken while the receiver keeps taking results.
//   When the receiver stalls, the output register holds its result, the input
//   stage fills, and in_tready drops until the result is taken.
//   Reset returns the link to idle with the read byte cleared and no result held; an idle
//   tick then shows all pins low, the data line released and the read value zero.

module rtc_three_wire_master_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // reg_index[2:0], value[10:3], io_in[11], zero pad
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // chip_enable[0], serial_clock[1], data_out[2],
                                  // data_drive[3], busy_res[4], done_res[5],
                                  // read_value[13:6], zero pad
);

  logic              in_v_r;
  rtc3w_pkg::req_t   in_d_r;
  logic              out_v_r;
  rtc3w_pkg::res_t   res_r;
  rtc3w_pkg::state_t st_r;
  rtc3w_pkg::state_t st_nxt;
  rtc3w_pkg::res_t   res_nxt;
  logic              out_free;
  logic              advance;

  assign out_free  = !out_v_r || out_tready;
  assign advance   = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;

  rtc3w_step u_step (
    .st     (st_r),
    .req    (in_d_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Input stage: take a request whenever the stage is empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_d_r.command   <= in_tuser;
      in_d_r.reg_index <= in_tdata[2:0];
      in_d_r.value     <= in_tdata[10:3];
      in_d_r.io_in     <= in_tdata[11];
    end
  end

  // Transfer state: advance once per request moved to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode        <= rtc3w_pkg::MODE_IDLE;
      st_r.bit_count   <= 5'd0;
      st_r.clock_phase <= 1'b0;
      st_r.shift_word  <= 16'd0;
      st_r.read_byte   <= 8'd0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

// ===== rtl/rtc3w_step.sv =====
// One-tick transfer logic of the three-wire RTC link master: next state and pin levels.
// Depends on rtc3w_pkg.
`timescale 1ns / 1ps

module rtc3w_step (
  input  rtc3w_pkg::state_t st,
  input  rtc3w_pkg::req_t   req,
  output rtc3w_pkg::state_t st_nxt,
  output rtc3w_pkg::res_t   res
);

  rtc3w_pkg::state_t st_start;
  logic              start;
  logic              reading;
  logic [7:0]        addr;
  logic [7:0]        wdata;

  // Latch a new transfer only while idle
  always_comb begin
    start = (st.mode == rtc3w_pkg::MODE_IDLE) &&
            ((req.command == rtc3w_pkg::CMD_WRITE) || (req.command == rtc3w_pkg::CMD_READ));
    addr  = rtc3w_pkg::ADDR_BASE + {4'd0, req.reg_index, 1'b0};
    wdata = (req.reg_index == rtc3w_pkg::WP_INDEX) ? req.value : rtc3w_pkg::to_bcd(req.value);
    st_start = st;
    if (start) begin
      st_start.bit_count   = 5'd0;
      st_start.clock_phase = 1'b0;
      if (req.command == rtc3w_pkg::CMD_READ) begin
        st_start.mode       = rtc3w_pkg::MODE_READ;
        st_start.read_byte  = 8'd0;
        st_start.shift_word = {8'd0, addr | 8'd1};
      end else begin
        st_start.mode       = rtc3w_pkg::MODE_WRITE;
        st_start.shift_word = {wdata, addr};
      end
    end
  end

  // Advance the running transfer by one half-bit
  always_comb begin
    st_nxt  = st_start;
    res     = '0;
    reading = 1'b0;
    res.read_value = rtc3w_pkg::from_bcd(st_start.read_byte);
    if (st_start.mode != rtc3w_pkg::MODE_IDLE) begin
      if (st_start.bit_count >= rtc3w_pkg::TOTAL_BITS) begin
        res.done_res       = 1'b1;
        st_nxt.mode        = rtc3w_pkg::MODE_IDLE;
        st_nxt.bit_count   = 5'd0;
        st_nxt.clock_phase = 1'b0;
      end else begin
        reading = (st_start.mode == rtc3w_pkg::MODE_READ) &&
                  (st_start.bit_count >= rtc3w_pkg::ADDR_BITS);
        res.chip_enable  = 1'b1;
        res.busy_res     = 1'b1;
        res.serial_clock = st_start.clock_phase;
        if (!reading) begin
          res.data_drive = 1'b1;
          res.data_out   = st_start.shift_word[st_start.bit_count[3:0]];
        end else if (st_start.clock_phase && req.io_in) begin
          // sample on the clock-high tick
          st_nxt.read_byte[st_start.bit_count[2:0]] = 1'b1;
          res.read_value = rtc3w_pkg::from_bcd(st_nxt.read_byte);
        end
        st_nxt.clock_phase = ~st_start.clock_phase;
        if (st_start.clock_phase) begin
          st_nxt.bit_count = st_start.bit_count + 5'd1;
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for the three-wire RTC link master: drives tick requests with start commands,
// predicts the pin levels, flags and read value of every tick, and compares each result.
// Depends on rtc3w_pkg and rtc_three_wire_master_core.
`timescale 1ns / 1ps

// Spare command code, treated by the block as a plain tick
localparam logic [1:0] CMD_SPARE = 2'd3;

class link_scoreboard;
  rtc3w_pkg::mode_t mode;
  logic [4:0]       bit_idx;
  logic             phase_hi;
  logic [15:0]      shift_reg;
  logic [7:0]       rx_byte;
  rtc3w_pkg::res_t  expected_pins[$];
  int               errors;

  function new();
    mode      = rtc3w_pkg::MODE_IDLE;
    bit_idx   = '0;
    phase_hi  = 1'b0;
    shift_reg = '0;
    rx_byte   = '0;
    errors    = 0;
  endfunction

  function int pending();
    return expected_pins.size();
  endfunction

  // Advance the link by one tick and queue the pin levels it must show
  function void note_request(logic [1:0] cmd, logic [2:0] idx, logic [7:0] val, logic io);
    rtc3w_pkg::res_t r;
    logic [7:0]      addr;
    logic [7:0]      wdata;
    r = '0;
    // Latch a start only while idle
    if (mode == rtc3w_pkg::MODE_IDLE &&
        (cmd == rtc3w_pkg::CMD_WRITE || cmd == rtc3w_pkg::CMD_READ)) begin
      addr  = rtc3w_pkg::ADDR_BASE + {4'd0, idx, 1'b0};
      wdata = 8'h00;
      if (cmd == rtc3w_pkg::CMD_READ) begin
        addr[0] = 1'b1;
        rx_byte = 8'h00;
        mode    = rtc3w_pkg::MODE_READ;
      end else begin
        // BCD: tens in the high nibble, wrapped to 8 bits above 99
        wdata = (idx == rtc3w_pkg::WP_INDEX) ? val
              : 8'((val / 8'd10) * 8'd16 + (val % 8'd10));
        mode  = rtc3w_pkg::MODE_WRITE;
      end
      shift_reg = {wdata, addr};
      bit_idx   = '0;
      phase_hi  = 1'b0;
    end
    if (mode != rtc3w_pkg::MODE_IDLE) begin
      if (bit_idx >= rtc3w_pkg::TOTAL_BITS) begin
        // Finishing tick: pins drop, done pulses
        r.done_res = 1'b1;
        mode       = rtc3w_pkg::MODE_IDLE;
        bit_idx    = '0;
        phase_hi   = 1'b0;
      end else begin
        r.chip_enable  = 1'b1;
        r.busy_res     = 1'b1;
        r.serial_clock = phase_hi;
        if (!(mode == rtc3w_pkg::MODE_READ && bit_idx >= rtc3w_pkg::ADDR_BITS)) begin
          r.data_drive = 1'b1;
          r.data_out   = shift_reg[bit_idx[3:0]];
        end else if (phase_hi && io) begin
          // Sample the slave bit on the clock-high tick
          rx_byte[bit_idx[2:0]] = 1'b1;
        end
        if (phase_hi) begin
          phase_hi = 1'b0;
          bit_idx  = bit_idx + 5'd1;
        end else begin
          phase_hi = 1'b1;
        end
      end
    end
    r.read_value = 8'(rx_byte[7:4] * 8'd10) + {4'd0, rx_byte[3:0]};
    expected_pins.push_back(r);
  endfunction

  function void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare one result word with the oldest expected tick
  function void check_result(logic [15:0] word);
    rtc3w_pkg::res_t want;
    rtc3w_pkg::res_t got;
    if (expected_pins.size() == 0) begin
      $display("%0t: result %h arrived with no request pending", $time, word);
      errors++;
      return;
    end
    want = expected_pins.pop_front();
    got  = rtc3w_pkg::res_t'(word[13:0]);
    check_field("chip_enable", 8'(want.chip_enable), 8'(got.chip_enable));
    check_field("serial_clock", 8'(want.serial_clock), 8'(got.serial_clock));
    check_field("data_out", 8'(want.data_out), 8'(got.data_out));
    check_field("data_drive", 8'(want.data_drive), 8'(got.data_drive));
    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
    check_field("read_value", want.read_value, got.read_value);
    check_field("pad", 8'd0, 8'(word[15:14]));
  endfunction
endclass

module tb;
  localparam int RANDOM_ITEMS = 1560;
  localparam int HOLD_CYCLES  = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // reg_index[2:0], value[10:3], io_in[11], zero pad
  logic [1:0]  in_tuser;   // command[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // chip_enable[0], serial_clock[1], data_out[2], data_drive[3],
                           // busy_res[4], done_res[5], read_value[13:6], zero pad

  link_scoreboard sb;
  int  sent;
  int  link_left;   // ticks left in the transfer as seen by the sender
  bit  hold_off;
  bit  no_gaps;

  rtc_three_wire_master_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Note accepted requests and check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(in_tuser, in_tdata[2:0], in_tdata[10:3], in_tdata[11]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata);
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_item(logic [1:0] cmd, logic [2:0] idx, logic [7:0] val, logic io);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'd0, io, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (link_left == 0) begin
      if (cmd == rtc3w_pkg::CMD_WRITE || cmd == rtc3w_pkg::CMD_READ) link_left = 32;
    end else begin
      link_left--;
    end
  endtask

  // Run one whole transfer from idle; one stray command lands mid-transfer
  task automatic run_transfer(logic [1:0] start_cmd, logic [2:0] idx, logic [7:0] val,
                              logic [7:0] slave_byte, logic [1:0] busy_cmd,
                              logic [1:0] end_cmd);
    int t;
    int k;
    int busy_at;
    busy_at = $urandom_range(1, 31);
    while (link_left != 0)
      send_item(rtc3w_pkg::CMD_TICK, 3'($urandom), 8'($urandom), 1'($urandom));
    send_item(start_cmd, idx, val, 1'($urandom));
    for (t = 1; t < 32; t++) begin
      k = t / 2;
      send_item((t == busy_at) ? busy_cmd : rtc3w_pkg::CMD_TICK, 3'($urandom),
                8'($urandom), (k >= 8) ? slave_byte[k - 8] : 1'($urandom));
    end
    send_item(end_cmd, 3'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        stall = no_gaps ? 0 : pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int base;
    int round;
    int wait_cnt;
    logic [1:0] start_cmd;
    logic [7:0] val;
    logic [7:0] slave_byte;
    sb        = new();
    sent      = 0;
    link_left = 0;
    hold_off  = 1'b0;
    no_gaps   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= rtc3w_pkg::CMD_TICK;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle ticks with both tick codes
    send_item(rtc3w_pkg::CMD_TICK, 3'd0, 8'd0, 1'b0);
    send_item(CMD_SPARE, 3'd7, 8'hFF, 1'b1);
    // Extremes of the write value, raw write-protect byte, ignored starts
    run_transfer(rtc3w_pkg::CMD_WRITE, 3'd0, 8'd0, 8'h00, rtc3w_pkg::CMD_READ,
                 rtc3w_pkg::CMD_TICK);
    run_transfer(rtc3w_pkg::CMD_WRITE, 3'd6, 8'd99, 8'h00, rtc3w_pkg::CMD_WRITE,
                 rtc3w_pkg::CMD_READ);
    run_transfer(rtc3w_pkg::CMD_WRITE, 3'd1, 8'd255, 8'hFF, CMD_SPARE,
                 rtc3w_pkg::CMD_WRITE);
    run_transfer(rtc3w_pkg::CMD_WRITE, 3'd7, 8'hA5, 8'h00, rtc3w_pkg::CMD_TICK,
                 rtc3w_pkg::CMD_TICK);
    // Reads: all ones, all zeros, a plain BCD byte; start right after done
    run_transfer(rtc3w_pkg::CMD_READ, 3'd2, 8'd0, 8'hFF, rtc3w_pkg::CMD_WRITE,
                 rtc3w_pkg::CMD_TICK);
    run_transfer(rtc3w_pkg::CMD_READ, 3'd7, 8'd0, 8'h00, rtc3w_pkg::CMD_READ,
                 rtc3w_pkg::CMD_READ);
    run_transfer(rtc3w_pkg::CMD_READ, 3'd3, 8'd0, 8'h59, rtc3w_pkg::CMD_TICK,
                 rtc3w_pkg::CMD_TICK);
    run_transfer(rtc3w_pkg::CMD_WRITE, 3'd5, 8'd42, 8'h00, rtc3w_pkg::CMD_TICK,
                 rtc3w_pkg::CMD_TICK);

    // Random: mostly whole transfers with random content, some noise
    base  = sent;
    round = 0;
    while (sent - base < RANDOM_ITEMS) begin
      round++;
      if (round == 12) hold_off = 1'b1;
      if (round == 24) begin
        // Stop offering and wait until every result is back
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      no_gaps = (round >= 30 && round < 36);
      if ($urandom_range(0, 9) < 8) begin
        start_cmd  = ($urandom_range(0, 1) == 0) ? rtc3w_pkg::CMD_WRITE
                                                 : rtc3w_pkg::CMD_READ;
        val        = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 99));
        slave_byte = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                   : {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        run_transfer(start_cmd, 3'($urandom), val, slave_byte, 2'($urandom),
                     2'($urandom));
        repeat ($urandom_range(0, 2))
          send_item(($urandom_range(0, 1) == 0) ? rtc3w_pkg::CMD_TICK : CMD_SPARE,
                    3'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 12))
          send_item(2'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    wait_cnt = 0;
    while (sb.pending() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
